// ===== hdl/multichannel_sine_sample_generator_defines.svh =====
// Assertion macros shared by the sine sample generator RTL.
// Expects aclk and aresetn to be visible in the including module.
`ifndef MULTICHANNEL_SINE_SAMPLE_GENERATOR_DEFINES_SVH
`define MULTICHANNEL_SINE_SAMPLE_GENERATOR_DEFINES_SVH

// Checked only while out of reset.
`define MSSG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define MSSG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hdl/mssg_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the sine sample generator.
// No dependencies; every RTL module imports this package.
package mssg_pkg;

    localparam int NUM_CHANNELS    = 4;
    localparam int CH_W            = 2;
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
    localparam int QUARTER_LEN     = 1 << QUARTER_BITS;
    localparam int HALF_SPAN       = 2 * QUARTER_LEN;

    localparam int PHASE_W   = 32;
    localparam int CNT_W     = 32;
    localparam int CYC_W     = 8;
    localparam int GAIN_W    = 16;
    localparam int SET_W     = 48;
    localparam int MAG_W     = 15;
    localparam int VALUE_W   = 17;
    localparam int SPC_W     = 7;
    localparam int SIDX_W    = 6;
    localparam int ADDR_W    = 6;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = 3;

    // Register indexes; the four channel settings occupy indexes 0 to 3.
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SPC    = 3'd5;

    localparam logic [PHASE_W-1:0] PERIOD_RESET = 32'd1000;
    localparam logic [SPC_W-1:0]   SPC_RESET    = 7'd1;

    // Input operation codes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam longint unsigned PI_Q30   = 64'd3373259426;
    localparam longint unsigned ONE_Q30  = 64'd1 << 30;
    localparam longint unsigned SINE_MAX = 64'd32767;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0][GAIN_W-1:0]  gain;
        logic [NUM_CHANNELS-1:0][PHASE_W-1:0] incr;
        logic [PHASE_W-1:0]                   period;
        logic [SPC_W-1:0]                     spc;
    } cfg_t;

    typedef logic [MAG_W-1:0] qtab_t [QUARTER_LEN];

    // round(32767 * sin(pi/2 * j / QUARTER_LEN)) by a Q2.30 Taylor series.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (longint'(j) * PI_Q30 + longint'(QUARTER_LEN)) / HALF_SPAN;
        x2   = (x * x) >> 30;
        term = ((x * x2) >> 30) / 6;
        sum  = (x >= term) ? x - term : 64'd0;
        term = ((term * x2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 210;
        sum  = (sum >= term) ? sum - term : 64'd0;
        v    = (sum * SINE_MAX + (ONE_Q30 >> 1)) >> 30;
        if (v > SINE_MAX) begin
            v = SINE_MAX;
        end
        return MAG_W'(v);
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int i = 0; i < QUARTER_LEN; i++) begin
            t[i] = quarter_sine(i);
        end
        return t;
    endfunction

    localparam qtab_t            QSINE_TAB  = build_qtab();
    localparam logic [MAG_W-1:0] QSINE_PEAK = quarter_sine(QUARTER_LEN);

endpackage

// ===== hdl/mssg_apb_regs.sv =====
// APB configuration registers of the sine sample generator.
// Depends on mssg_pkg for the register map and the cfg_t bundle.
module mssg_apb_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mssg_pkg::ADDR_W-1:0]    paddr,
    input  logic [mssg_pkg::PDATA_W-1:0]   pwdata,
    output logic [mssg_pkg::PDATA_W-1:0]   prdata,
    output mssg_pkg::cfg_t                 cfg
);
    import mssg_pkg::*;

    logic [SET_W-1:0]     chan_reg [NUM_CHANNELS];
    logic [PHASE_W-1:0]   period_reg;
    logic [SPC_W-1:0]     spc_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Registers sit on 8-byte boundaries.
    assign reg_idx = paddr[ADDR_W-1 -: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                chan_reg[k] <= '0;
            end
            period_reg <= PERIOD_RESET;
            spc_reg    <= SPC_RESET;
        end else if (wr_en) begin
            priority if (reg_idx < REG_IDX_W'(NUM_CHANNELS)) begin
                chan_reg[reg_idx[CH_W-1:0]] <= pwdata[SET_W-1:0];
            end else if (reg_idx == REG_PERIOD) begin
                period_reg <= pwdata[PHASE_W-1:0];
            end else if (reg_idx == REG_SPC) begin
                spc_reg <= pwdata[SPC_W-1:0];
            end
        end
    end

    always_comb begin
        priority if (reg_idx < REG_IDX_W'(NUM_CHANNELS)) begin
            prdata = PDATA_W'(chan_reg[reg_idx[CH_W-1:0]]);
        end else if (reg_idx == REG_PERIOD) begin
            prdata = PDATA_W'(period_reg);
        end else if (reg_idx == REG_SPC) begin
            prdata = PDATA_W'(spc_reg);
        end else begin
            prdata = '0;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            cfg.gain[k] = chan_reg[k][SET_W-1 -: GAIN_W];
            cfg.incr[k] = chan_reg[k][PHASE_W-1:0];
        end
        cfg.period = period_reg;
        cfg.spc    = spc_reg;
    end

endmodule

// ===== hdl/mssg_mul_unit.sv =====
// Shared 32 by 32 multiplier keeping the low 32 product bits, registered.
// Depends on mssg_pkg for the operand width.
module mssg_mul_unit (
    input  logic                          aclk,
    input  logic [mssg_pkg::PHASE_W-1:0]  op_a,
    input  logic [mssg_pkg::PHASE_W-1:0]  op_b,
    output logic [mssg_pkg::PHASE_W-1:0]  product
);
    import mssg_pkg::*;

    logic [PHASE_W-1:0] product_reg;

    // Every use of the product wraps modulo 2^32, so the high half is never built.
    always_ff @(posedge aclk) begin
        product_reg <= PHASE_W'(op_a * op_b);
    end

    assign product = product_reg;

endmodule

// ===== hdl/mssg_sine_lut.sv =====
// Full-wave sine lookup built from the quarter-wave table, registered magnitude and sign.
// Depends on mssg_pkg for the table and its widths.
module mssg_sine_lut (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic [mssg_pkg::SINE_TABLE_BITS-1:0]  phase_idx,
    output logic [mssg_pkg::MAG_W-1:0]            mag,
    output logic                                  neg
);
    import mssg_pkg::*;

    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] offs;
    logic [QUARTER_BITS-1:0] offs_mirror;
    logic [MAG_W-1:0]        mag_next;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;

    assign quad        = phase_idx[SINE_TABLE_BITS-1 -: 2];
    assign offs        = phase_idx[QUARTER_BITS-1:0];
    assign offs_mirror = ~offs + QUARTER_BITS'(1);

    // Odd quadrants run the table backwards; their first entry is the peak.
    always_comb begin
        if (!quad[0]) begin
            mag_next = QSINE_TAB[offs];
        end else if (offs == '0) begin
            mag_next = QSINE_PEAK;
        end else begin
            mag_next = QSINE_TAB[offs_mirror];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mag_reg <= mag_next;
            neg_reg <= quad[1];
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

// ===== hdl/multichannel_sine_sample_generator.sv =====
// Top level of the four-channel sine sample generator: sequencer and output register.
// Depends on mssg_pkg, mssg_apb_regs, mssg_mul_unit, mssg_sine_lut and the defines header.
//
// Usage: a transaction on the s_ channel is either a tick or a restart. A tick adds
// s_cycles_elapsed to the 32-bit cycle counter and then produces one m_ transaction per
// sample (samples_per_cycle, capped at MAX_SAMPLES), each with counter, time in
// microseconds, sample index, last-sample flag and four channel values gain*sin(phase).
// A restart clears the counter and produces nothing.
// All multiplications run through one shared 32x32 multiplier under a small sequencer,
// and s_ready is low while a tick occupies the block. Each sample needs 8
// multiplier passes and 4 table lookups, plus a hand-off to the output register.
// The output register lets the sequencer start the next sample while a result waits;
// when the receiver stalls, the sequencer holds at its hand-off step until the
// register frees up. A pending result also lets a new tick be accepted.
// Reset (aresetn low, synchronous) clears counter and handshakes, loads register defaults;
// the user writes configuration via the APB port only while idle (the block does not check).
`include "multichannel_sine_sample_generator_defines.svh"

module multichannel_sine_sample_generator #(
    parameter int MAX_SAMPLES = mssg_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mssg_pkg::ADDR_W-1:0]         paddr,
    input  logic [mssg_pkg::PDATA_W-1:0]        pwdata,
    output logic [mssg_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [mssg_pkg::CYC_W-1:0]          s_cycles_elapsed,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mssg_pkg::CNT_W-1:0]          m_cycle_count,
    output logic [mssg_pkg::PHASE_W-1:0]        m_time_usec,
    output logic [mssg_pkg::SIDX_W-1:0]         m_sample_index,
    output logic signed [mssg_pkg::VALUE_W-1:0] m_value_ch0,
    output logic signed [mssg_pkg::VALUE_W-1:0] m_value_ch1,
    output logic signed [mssg_pkg::VALUE_W-1:0] m_value_ch2,
    output logic signed [mssg_pkg::VALUE_W-1:0] m_value_ch3,
    output logic                                m_last_sample
);
    import mssg_pkg::*;

    localparam int SCNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int ST_W   = 4;

    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_TIME  = 4'd1;
    localparam logic [ST_W-1:0] ST_BASE  = 4'd2;
    localparam logic [ST_W-1:0] ST_SETUP = 4'd3;
    localparam logic [ST_W-1:0] ST_PHASE = 4'd4;
    localparam logic [ST_W-1:0] ST_LOOK  = 4'd5;
    localparam logic [ST_W-1:0] ST_GAIN  = 4'd6;
    localparam logic [ST_W-1:0] ST_STORE = 4'd7;
    localparam logic [ST_W-1:0] ST_EMIT  = 4'd8;

    cfg_t cfg;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next, ch_inc;
    logic [SCNT_W-1:0] s_reg, s_next;
    logic [SCNT_W-1:0] n_reg, n_next, n_sat;
    logic [CNT_W-1:0]  counter_reg, counter_next;
    logic              m_valid_reg, m_valid_next;

    logic [PHASE_W-1:0] time_reg;
    logic [PHASE_W-1:0] base_reg;
    logic signed [VALUE_W-1:0] vals_reg [NUM_CHANNELS];

    logic [PHASE_W-1:0] op_a, op_b, product, idx;
    logic [MAG_W-1:0]   lut_mag;
    logic               lut_neg, lut_load;
    logic               time_load, base_load, val_load, out_load;
    logic               out_free, last;
    logic [VALUE_W-1:0] scaled;
    logic [VALUE_W-1:0] val_new;

    mssg_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mssg_mul_unit u_mul (
        .aclk    (aclk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    mssg_sine_lut u_lut (
        .aclk      (aclk),
        .load      (lut_load),
        .phase_idx (product[PHASE_W-1 -: SINE_TABLE_BITS]),
        .mag       (lut_mag),
        .neg       (lut_neg)
    );

    assign pready   = 1'b1;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign ch_inc   = ch_reg + CH_W'(1);
    assign idx      = base_reg + PHASE_W'(s_reg);
    assign last     = (s_reg == n_reg - SCNT_W'(1));
    assign n_sat    = (cfg.spc > SPC_W'(MAX_SAMPLES)) ? SCNT_W'(MAX_SAMPLES)
                                                      : SCNT_W'(cfg.spc);

    // Magnitude times gain, shifted down by 15; the sign is applied afterwards,
    // which truncates toward zero.
    assign scaled  = product[PHASE_W-1 -: VALUE_W];
    assign val_new = lut_neg ? (~scaled + VALUE_W'(1)) : scaled;

    always_comb begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        s_next       = s_reg;
        n_next       = n_reg;
        counter_next = counter_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op_a         = '0;
        op_b         = '0;
        lut_load     = 1'b0;
        time_load    = 1'b0;
        base_load    = 1'b0;
        val_load     = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_RESTART) begin
                        counter_next = '0;
                    end else begin
                        counter_next = counter_reg + CNT_W'(s_cycles_elapsed);
                        n_next       = n_sat;
                        state_next   = ST_TIME;
                    end
                end
            end
            ST_TIME: begin
                op_a       = counter_reg;
                op_b       = cfg.period;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                time_load  = 1'b1;
                op_a       = counter_reg;
                op_b       = PHASE_W'(n_reg);
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                base_load  = 1'b1;
                s_next     = '0;
                ch_next    = '0;
                state_next = (n_reg == '0) ? ST_IDLE : ST_PHASE;
            end
            ST_PHASE: begin
                op_a       = idx;
                op_b       = cfg.incr[ch_reg];
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                lut_load   = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                op_a       = PHASE_W'(lut_mag);
                op_b       = PHASE_W'(cfg.gain[ch_reg]);
                state_next = ST_STORE;
            end
            ST_STORE: begin
                val_load = 1'b1;
                if (ch_reg == CH_W'(NUM_CHANNELS - 1)) begin
                    state_next = ST_EMIT;
                end else begin
                    // The next channel's phase product starts while this value is stored.
                    ch_next    = ch_inc;
                    op_a       = idx;
                    op_b       = cfg.incr[ch_inc];
                    state_next = ST_LOOK;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    if (last) begin
                        state_next = ST_IDLE;
                    end else begin
                        s_next     = s_reg + SCNT_W'(1);
                        ch_next    = '0;
                        state_next = ST_PHASE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= '0;
            s_reg       <= '0;
            n_reg       <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            s_reg       <= s_next;
            n_reg       <= n_next;
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (time_load) begin
            time_reg <= product;
        end
        if (base_load) begin
            base_reg <= product;
        end
        if (val_load) begin
            vals_reg[ch_reg] <= val_new;
        end
        if (out_load) begin
            m_cycle_count  <= counter_reg;
            m_time_usec    <= time_reg;
            m_sample_index <= SIDX_W'(s_reg);
            m_value_ch0    <= vals_reg[0];
            m_value_ch1    <= vals_reg[1];
            m_value_ch2    <= vals_reg[2];
            m_value_ch3    <= vals_reg[3];
            m_last_sample  <= last;
        end
    end

    assign m_valid = m_valid_reg;

    `MSSG_ASSERT(a_counter_hold, state_reg != ST_IDLE |=> $stable(counter_reg), "cycle counter changed during a tick")
    `MSSG_ASSERT(a_restart_clears, (s_valid && s_ready && s_operation == OP_RESTART) |=> (counter_reg == '0), "restart did not clear the cycle counter")
    `MSSG_ASSERT(a_sample_in_range, (state_reg == ST_PHASE) |-> (s_reg < n_reg), "sample index ran past the sample count")
    `MSSG_ASSERT(a_emit_loads, (state_reg == ST_EMIT && out_free) |=> m_valid, "finished sample was not handed to the output")
    `MSSG_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE && !m_valid), "reset did not idle the sequencer")

endmodule
